FILE: sv/npn_next_protocol_parser_defines.svh
// Assertion helpers used by the checker file.
`ifndef NPN_NEXT_PROTOCOL_PARSER_DEFINES_SVH
`define NPN_NEXT_PROTOCOL_PARSER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define NPN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define NPN_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: sv/npn_pkg.sv
package npn_pkg;

    typedef enum logic [2:0] {
        PH_LEN    = 3'd0,
        PH_NAME   = 3'd1,
        PH_PADLEN = 3'd2,
        PH_PAD    = 3'd3,
        PH_END    = 3'd4,
        PH_ERR    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_BAD_PADL = 3'd2,
        ST_PAD_NZ   = 3'd3,
        ST_TRAILING = 3'd4,
        ST_TRUNC    = 3'd5
    } status_t;

    // One classified byte, as handed from the parser to the output side.
    typedef struct packed {
        logic [7:0] data;
        logic       name_valid;
        logic       done;
        status_t    status;
    } cls_t;

    localparam logic [7:0] MAX_LEN_RESET = 8'd255;
    localparam logic [5:0] PAD_BLOCK     = 6'd32;
    localparam logic [4:0] LEN_OVERHEAD  = 5'd2;

endpackage

FILE: sv/npn_next_protocol_parser.sv
// Next Protocol Negotiation message checker.
// Input channel (s_*): one body byte per transaction, s_last_byte marks the
// final byte of the body. Output channel (m_*): exactly one transaction per
// input byte, in order. m_name_valid flags a protocol name byte passed out in
// m_name_byte (zero otherwise); m_message_done copies the last flag and then
// m_status holds 0 ok, 1 name too long, 2 bad pad length, 3 nonzero pad,
// 4 trailing data, 5 truncated (zero on other transactions).
// cfg_we/cfg_wdata write the largest accepted name length (reset 255);
// write it only while no transactions are in flight.
// An accepted byte is written into the queue and from there loaded into the
// output register that drives m_valid. Throughput: one byte per cycle while
// s_ready is high, as the parser state updates on every accepted byte.
// Reset (aresetn low, synchronous) empties the queue and output register and
// returns the parser to expect a name length byte.
// When the receiver stalls, the output register holds and the queue fills;
// s_ready drops once QUEUE_DEPTH results wait in the queue behind the held
// output register (QUEUE_DEPTH + 1 in all) and rises again as soon as the
// receiver takes one. s_ready does not depend on m_ready combinationally.
module npn_next_protocol_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    // config
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    // input bytes
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    // results
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_name_byte,
    output logic       m_name_valid,
    output logic       m_message_done,
    output logic [2:0] m_status
);

    npn_pkg::cls_t push_data;
    npn_pkg::cls_t pop_data;
    logic          push;
    logic          q_full;
    logic          pop;
    logic          q_not_empty;

    // Front: parser state machine, classifies each byte as it is accepted.
    npn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (push),
        .q_data      (push_data)
    );

    // Short queue decoupling the parser from output backpressure.
    npn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    // Back: formats results and owns the output register.
    npn_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_data         (pop_data),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_name_byte    (m_name_byte),
        .m_name_valid   (m_name_valid),
        .m_message_done (m_message_done),
        .m_status       (m_status)
    );

endmodule

FILE: sv/npn_front.sv
module npn_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    input  logic           s_last_byte,
    input  logic           q_full,
    output logic           q_push,
    output npn_pkg::cls_t  q_data
);

    npn_pkg::phase_t  phase_reg, phase_next, step_phase;
    npn_pkg::status_t err_reg, err_next, step_err;
    logic [7:0] left_reg, left_next;
    logic [5:0] exp_pad_reg, exp_pad_next;
    logic [7:0] max_len_reg;
    logic [4:0] mod_v;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    // (len + 2) mod 32, then the pad length that rounds up to the block
    assign mod_v = s_data_byte[4:0] + npn_pkg::LEN_OVERHEAD;

    always_comb begin
        step_phase   = phase_reg;
        step_err     = err_reg;
        left_next    = left_reg;
        exp_pad_next = exp_pad_reg;
        case (phase_reg)
            npn_pkg::PH_LEN: begin
                if (s_data_byte > max_len_reg) begin
                    step_err   = npn_pkg::ST_TOO_LONG;
                    step_phase = npn_pkg::PH_ERR;
                end else begin
                    exp_pad_next = npn_pkg::PAD_BLOCK - {1'b0, mod_v};
                    left_next    = s_data_byte;
                    step_phase   = (s_data_byte != 8'd0) ? npn_pkg::PH_NAME
                                                         : npn_pkg::PH_PADLEN;
                end
            end
            npn_pkg::PH_NAME: begin
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1) begin
                    step_phase = npn_pkg::PH_PADLEN;
                end
            end
            npn_pkg::PH_PADLEN: begin
                if (s_data_byte != {2'b00, exp_pad_reg}) begin
                    step_err   = npn_pkg::ST_BAD_PADL;
                    step_phase = npn_pkg::PH_ERR;
                end else begin
                    left_next  = s_data_byte;
                    step_phase = (s_data_byte != 8'd0) ? npn_pkg::PH_PAD
                                                       : npn_pkg::PH_END;
                end
            end
            npn_pkg::PH_PAD: begin
                if (s_data_byte != 8'd0) begin
                    step_err   = npn_pkg::ST_PAD_NZ;
                    step_phase = npn_pkg::PH_ERR;
                end else begin
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1) begin
                        step_phase = npn_pkg::PH_END;
                    end
                end
            end
            npn_pkg::PH_END: begin
                step_err   = npn_pkg::ST_TRAILING;
                step_phase = npn_pkg::PH_ERR;
            end
            default: begin
            end
        endcase

        phase_next = step_phase;
        err_next   = step_err;
        // last byte closes the message and rearms for the next one
        if (s_last_byte) begin
            phase_next   = npn_pkg::PH_LEN;
            err_next     = npn_pkg::ST_OK;
            left_next    = 8'd0;
            exp_pad_next = 6'd0;
        end
    end

    always_comb begin
        q_data.data       = s_data_byte;
        q_data.name_valid = (phase_reg == npn_pkg::PH_NAME);
        q_data.done       = s_last_byte;
        q_data.status     = npn_pkg::ST_OK;
        if (s_last_byte) begin
            case (step_phase)
                npn_pkg::PH_ERR: q_data.status = step_err;
                npn_pkg::PH_END: q_data.status = npn_pkg::ST_OK;
                default:         q_data.status = npn_pkg::ST_TRUNC;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= npn_pkg::PH_LEN;
            err_reg     <= npn_pkg::ST_OK;
            left_reg    <= 8'd0;
            exp_pad_reg <= 6'd0;
            max_len_reg <= npn_pkg::MAX_LEN_RESET;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg   <= phase_next;
                err_reg     <= err_next;
                left_reg    <= left_next;
                exp_pad_reg <= exp_pad_next;
            end
        end
    end

endmodule

FILE: sv/npn_queue.sv
module npn_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  npn_pkg::cls_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output npn_pkg::cls_t  pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    npn_pkg::cls_t  entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/npn_back.sv
module npn_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_not_empty,
    input  npn_pkg::cls_t  q_data,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_name_byte,
    output logic           m_name_valid,
    output logic           m_message_done,
    output logic [2:0]     m_status
);

    logic       valid_reg;
    logic [7:0] name_byte_reg, name_byte_next;
    logic       name_valid_reg;
    logic       done_reg;
    logic [2:0] status_reg, status_next;

    // refill the output register when empty or being drained
    assign q_pop = q_not_empty && (!valid_reg || m_ready);

    // non-name bytes go out as zero; status only shown on the closing byte
    assign name_byte_next = q_data.name_valid ? q_data.data : 8'd0;
    assign status_next    = q_data.done ? q_data.status : npn_pkg::ST_OK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            name_byte_reg  <= name_byte_next;
            name_valid_reg <= q_data.name_valid;
            done_reg       <= q_data.done;
            status_reg     <= status_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_name_byte    = name_byte_reg;
    assign m_name_valid   = name_valid_reg;
    assign m_message_done = done_reg;
    assign m_status       = status_reg;

endmodule

FILE: sv/npn_checker.sv
`include "npn_next_protocol_parser_defines.svh"

module npn_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_name_byte,
    input logic       m_name_valid,
    input logic       m_message_done,
    input logic [2:0] m_status
);

    `NPN_ASSERT_RST(a_rst_clears_out, !aresetn |=> !m_valid, "output valid after reset")

    `NPN_ASSERT(a_out_hold,
        m_valid && !m_ready |=> m_valid && $stable(m_name_byte) && $stable(m_name_valid)
            && $stable(m_message_done) && $stable(m_status),
        "stalled result changed")

    `NPN_ASSERT(a_status_only_done,
        m_valid && !m_message_done |-> m_status == npn_pkg::ST_OK,
        "status outside closing transaction")

    `NPN_ASSERT(a_name_zero, m_valid && !m_name_valid |-> m_name_byte == 8'd0,
        "non-name byte not zero")

    `NPN_ASSERT(a_name_last_trunc,
        m_valid && m_name_valid && m_message_done |-> m_status == npn_pkg::ST_TRUNC,
        "name byte as last must be truncated")

endmodule

bind npn_next_protocol_parser npn_checker u_npn_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_name_byte    (m_name_byte),
    .m_name_valid   (m_name_valid),
    .m_message_done (m_message_done),
    .m_status       (m_status)
);
